### design/bab_pkg.sv
// Shared constants and types for the border aware box filter.
package bab_pkg;

    localparam int PIXEL_W        = 8;
    localparam int CFG_IDX_W      = 2;
    localparam int CFG_DATA_W     = 11;
    localparam int RADIUS_REG_W   = 2;

    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_HEIGHT = 1024;
    localparam int DEF_MAX_RADIUS = 3;

    localparam logic [RADIUS_REG_W-1:0] RST_RADIUS = 2'd1;
    localparam logic [CFG_DATA_W-1:0]   RST_WIDTH  = 11'd640;
    localparam logic [CFG_DATA_W-1:0]   RST_HEIGHT = 11'd480;

    localparam logic [CFG_IDX_W-1:0] CFG_RADIUS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd2;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_SCAN,
        BK_DIV,
        BK_OUT
    } t_back_state;

endpackage

### design/bab_intf.sv
// Channel interfaces: pixel input, result output, configuration writes.
interface bab_pix_if import bab_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [PIXEL_W-1:0] pixel;
    logic               flush;
    modport source (output valid, output pixel, output flush, input ready);
    modport sink   (input valid, input pixel, input flush, output ready);
endinterface

interface bab_res_if import bab_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [PIXEL_W-1:0] mean_value;
    logic               frame_end;
    modport source (output valid, output mean_value, output frame_end, input ready);
    modport sink   (input valid, input mean_value, input frame_end, output ready);
endinterface

interface bab_cfg_if import bab_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

### design/bab_line_mem.sv
// Line store: ring of rows, one write port, one registered read port.
module bab_line_mem import bab_pkg::*; #(
    parameter int RING      = 8,
    parameter int MAX_WIDTH = DEF_MAX_WIDTH,
    parameter int RW        = $clog2(RING),
    parameter int CW        = $clog2(MAX_WIDTH)
) (
    input  logic               i_clk,
    input  logic               i_we,
    input  logic [RW-1:0]      i_wring,
    input  logic [CW-1:0]      i_wcol,
    input  logic [PIXEL_W-1:0] i_wdata,
    input  logic [RW-1:0]      i_rring,
    input  logic [CW-1:0]      i_rcol,
    output logic [PIXEL_W-1:0] o_rdata
);
    logic [PIXEL_W-1:0] r_mem [RING][MAX_WIDTH];
    logic [PIXEL_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wring][i_wcol] <= i_wdata;
        end
        r_rdata <= r_mem[i_rring][i_rcol];
    end

    assign o_rdata = r_rdata;
endmodule

### design/bab_job_fifo.sv
// Two-entry queue of output jobs between front and back.
module bab_job_fifo #(
    parameter int W = 8
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    input  logic         i_pop,
    output logic [W-1:0] o_data,
    output logic         o_empty,
    output logic         o_full
);
    logic [W-1:0] r_mem [2];
    logic         r_wp, r_rp;
    logic [1:0]   r_cnt;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) r_wp <= ~r_wp;
            if (i_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end

    assign o_data  = r_mem[r_rp];
    assign o_empty = (r_cnt == 2'd0);
    assign o_full  = (r_cnt == 2'd2);
endmodule

### design/bab_front.sv
// Front: config registers, input/output position tracking, line store writes, job issue.
module bab_front import bab_pkg::*; #(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
    parameter int MAX_RADIUS = DEF_MAX_RADIUS,
    parameter int RING       = 2 * MAX_RADIUS + 2,
    parameter int RW         = $clog2(RING),
    parameter int CW         = $clog2(MAX_WIDTH),
    parameter int HW         = $clog2(MAX_HEIGHT),
    parameter int DW         = $clog2(MAX_WIDTH + 1),
    parameter int HDW        = $clog2(MAX_HEIGHT + 1),
    parameter int RADW       = $clog2(MAX_RADIUS + 1),
    parameter int JW         = HW + CW + RW + 1
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    bab_pix_if.sink            i_pix,
    bab_cfg_if.sink            i_cfg,
    input  logic               i_fifo_empty,
    input  logic               i_fifo_full,
    input  logic               i_back_idle,
    output logic               o_push,
    output logic [JW-1:0]      o_job,
    output logic               o_we,
    output logic [RW-1:0]      o_wring,
    output logic [CW-1:0]      o_wcol,
    output logic [PIXEL_W-1:0] o_wdata,
    output logic [RADW-1:0]    o_eff_r,
    output logic [DW-1:0]      o_eff_w,
    output logic [HDW-1:0]     o_eff_h
);
    localparam int NW = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);

    logic [RADIUS_REG_W-1:0] r_radius;
    logic [CFG_DATA_W-1:0]   r_width, r_height;
    logic                    r_settle;
    logic [NW-1:0]           r_total, r_lag;
    logic [NW-1:0]           r_in_cnt, r_out_cnt, n_in_cnt, n_out_cnt;
    logic [CW-1:0]           r_in_col, r_out_col, n_in_col, n_out_col;
    logic [RW-1:0]           r_in_ring, r_out_ring, n_in_ring, n_out_ring;
    logic [HW-1:0]           r_out_row, n_out_row;

    logic [31:0] rad_ext, w_ext, h_ext;
    logic        cfg_acc, pix_acc, in_phase, store, emit, last, restart;
    logic [NW-1:0] in_inc, out_inc;

    assign rad_ext = 32'(r_radius);
    assign w_ext   = 32'(r_width);
    assign h_ext   = 32'(r_height);
    assign o_eff_r = RADW'((rad_ext > MAX_RADIUS) ? MAX_RADIUS : rad_ext);
    assign o_eff_w = DW'((w_ext == 0) ? 1 : ((w_ext > MAX_WIDTH) ? MAX_WIDTH : w_ext));
    assign o_eff_h = HDW'((h_ext == 0) ? 1 : ((h_ext > MAX_HEIGHT) ? MAX_HEIGHT : h_ext));

    assign cfg_acc     = i_cfg.valid && i_cfg.ready;
    assign i_cfg.ready = 1'b1;

    assign in_phase = (r_in_cnt < r_total);
    always_comb begin
        if (r_settle || i_cfg.valid) begin
            i_pix.ready = 1'b0;
        end else if (in_phase) begin
            // a store must not race reads of the job in flight
            i_pix.ready = i_pix.flush || (i_fifo_empty && i_back_idle);
        end else begin
            i_pix.ready = !i_fifo_full;
        end
    end
    assign pix_acc = i_pix.valid && i_pix.ready;

    assign in_inc  = r_in_cnt + NW'(1);
    assign out_inc = r_out_cnt + NW'(1);
    assign store   = pix_acc && in_phase && !i_pix.flush;
    assign emit    = pix_acc && (!in_phase ||
                     (!i_pix.flush && ((in_inc - r_out_cnt) > r_lag)));
    assign last    = (out_inc >= r_total);
    assign restart = cfg_acc || (emit && last);

    always_comb begin
        n_in_cnt   = r_in_cnt;
        n_in_col   = r_in_col;
        n_in_ring  = r_in_ring;
        n_out_cnt  = r_out_cnt;
        n_out_col  = r_out_col;
        n_out_row  = r_out_row;
        n_out_ring = r_out_ring;
        if (store) begin
            n_in_cnt = in_inc;
            if (DW'(r_in_col) + DW'(1) >= o_eff_w) begin
                n_in_col  = '0;
                n_in_ring = (32'(r_in_ring) == RING - 1) ? '0 : r_in_ring + RW'(1);
            end else begin
                n_in_col = r_in_col + CW'(1);
            end
        end
        if (emit) begin
            n_out_cnt = out_inc;
            if (DW'(r_out_col) + DW'(1) >= o_eff_w) begin
                n_out_col  = '0;
                n_out_row  = r_out_row + HW'(1);
                n_out_ring = (32'(r_out_ring) == RING - 1) ? '0 : r_out_ring + RW'(1);
            end else begin
                n_out_col = r_out_col + CW'(1);
            end
        end
        if (restart) begin
            n_in_cnt   = '0;
            n_in_col   = '0;
            n_in_ring  = '0;
            n_out_cnt  = '0;
            n_out_col  = '0;
            n_out_row  = '0;
            n_out_ring = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_total <= NW'(o_eff_w) * NW'(o_eff_h);
        r_lag   <= NW'(o_eff_r) * NW'(o_eff_w) + NW'(o_eff_r);
        if (!i_rst_n) begin
            r_radius   <= RST_RADIUS;
            r_width    <= RST_WIDTH;
            r_height   <= RST_HEIGHT;
            r_settle   <= 1'b1;
            r_in_cnt   <= '0;
            r_in_col   <= '0;
            r_in_ring  <= '0;
            r_out_cnt  <= '0;
            r_out_col  <= '0;
            r_out_row  <= '0;
            r_out_ring <= '0;
        end else begin
            // totals are registered, so hold input off in the cycle after a write
            r_settle <= cfg_acc;
            if (cfg_acc) begin
                case (i_cfg.index)
                    CFG_RADIUS: r_radius <= i_cfg.data[RADIUS_REG_W-1:0];
                    CFG_WIDTH:  r_width  <= i_cfg.data;
                    CFG_HEIGHT: r_height <= i_cfg.data;
                    default:    ;
                endcase
            end
            r_in_cnt   <= n_in_cnt;
            r_in_col   <= n_in_col;
            r_in_ring  <= n_in_ring;
            r_out_cnt  <= n_out_cnt;
            r_out_col  <= n_out_col;
            r_out_row  <= n_out_row;
            r_out_ring <= n_out_ring;
        end
    end

    assign o_we    = store;
    assign o_wring = r_in_ring;
    assign o_wcol  = r_in_col;
    assign o_wdata = i_pix.pixel;
    assign o_push  = emit;
    assign o_job   = {r_out_row, r_out_col, r_out_ring, last};
endmodule

### design/bab_back.sv
// Back: scans the neighborhood from the line store, sums, divides, presents result.
module bab_back import bab_pkg::*; #(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
    parameter int MAX_RADIUS = DEF_MAX_RADIUS,
    parameter int RING       = 2 * MAX_RADIUS + 2,
    parameter int RW         = $clog2(RING),
    parameter int CW         = $clog2(MAX_WIDTH),
    parameter int HW         = $clog2(MAX_HEIGHT),
    parameter int DW         = $clog2(MAX_WIDTH + 1),
    parameter int HDW        = $clog2(MAX_HEIGHT + 1),
    parameter int RADW       = $clog2(MAX_RADIUS + 1),
    parameter int JW         = HW + CW + RW + 1
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_job_valid,
    input  logic [JW-1:0]      i_job,
    output logic               o_job_pop,
    input  logic [RADW-1:0]    i_eff_r,
    input  logic [DW-1:0]      i_eff_w,
    input  logic [HDW-1:0]     i_eff_h,
    output logic [RW-1:0]      o_rring,
    output logic [CW-1:0]      o_rcol,
    input  logic [PIXEL_W-1:0] i_rdata,
    output logic               o_idle,
    bab_res_if.source          o_res
);
    localparam int KMAX = (2 * MAX_RADIUS + 1) * (2 * MAX_RADIUS + 1);
    localparam int SW   = $clog2(KMAX * 255 + 1);
    localparam int CNW  = $clog2(KMAX + 1);
    localparam int DYW  = RADW + 1;
    localparam int YW   = HW + 2;
    localparam int XW   = CW + 2;
    localparam int TW   = RW + 2;
    localparam int STW  = $clog2(SW + 1);

    t_back_state r_state, n_state;

    logic [HW-1:0]     r_oy;
    logic [CW-1:0]     r_ox;
    logic [RW-1:0]     r_oring;
    logic              r_last;
    logic signed [DYW-1:0] r_dy, r_dx;
    logic              r_issue_done, r_pend;
    logic [SW-1:0]     r_sum;
    logic [CNW-1:0]    r_cnt;
    logic [CNW:0]      r_rem;
    logic [SW-1:0]     r_quot;
    logic [STW-1:0]    r_step;

    logic signed [DYW-1:0] rad_s, neg_r;
    logic signed [YW-1:0]  y;
    logic signed [XW-1:0]  x;
    logic signed [TW-1:0]  rt;
    logic                  inimg, issue_end;
    logic [RW-1:0]         ring;
    logic [CNW:0]          shifted;

    assign rad_s = signed'(DYW'(i_eff_r));
    assign neg_r = -rad_s;

    assign y = signed'(YW'(r_oy)) + YW'(r_dy);
    assign x = signed'(XW'(r_ox)) + XW'(r_dx);
    assign inimg = !y[YW-1] && (y[YW-2:0] < (YW-1)'(i_eff_h)) &&
                   !x[XW-1] && (x[XW-2:0] < (XW-1)'(i_eff_w));

    // ring row of oy+dy, one wrap either way
    assign rt = signed'(TW'(r_oring)) + TW'(r_dy);
    always_comb begin
        if (rt < 0) begin
            ring = RW'(rt + TW'(RING));
        end else if (rt >= TW'(RING)) begin
            ring = RW'(rt - TW'(RING));
        end else begin
            ring = RW'(rt);
        end
    end

    assign o_rring   = inimg ? ring : '0;
    assign o_rcol    = inimg ? x[CW-1:0] : '0;
    assign issue_end = (r_dx == rad_s) && (r_dy == rad_s);
    assign shifted   = {r_rem[CNW-1:0], r_quot[SW-1]};

    always_comb begin
        n_state   = r_state;
        o_job_pop = 1'b0;
        case (r_state)
            BK_IDLE: begin
                o_job_pop = i_job_valid;
                if (i_job_valid) n_state = BK_SCAN;
            end
            BK_SCAN: begin
                if (r_issue_done && !r_pend) n_state = BK_DIV;
            end
            BK_DIV: begin
                if (32'(r_step) == SW - 1) n_state = BK_OUT;
            end
            BK_OUT: begin
                if (o_res.ready) n_state = BK_IDLE;
            end
            default: n_state = BK_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BK_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            BK_IDLE: begin
                {r_oy, r_ox, r_oring, r_last} <= i_job;
                r_dy         <= neg_r;
                r_dx         <= neg_r;
                r_issue_done <= 1'b0;
                r_pend       <= 1'b0;
                r_sum        <= '0;
                r_cnt        <= '0;
            end
            BK_SCAN: begin
                r_pend <= !r_issue_done && inimg;
                if (r_pend) begin
                    r_sum <= r_sum + SW'(i_rdata);
                    r_cnt <= r_cnt + CNW'(1);
                end
                if (!r_issue_done) begin
                    if (issue_end) begin
                        r_issue_done <= 1'b1;
                    end else if (r_dx == rad_s) begin
                        r_dx <= neg_r;
                        r_dy <= r_dy + DYW'(1);
                    end else begin
                        r_dx <= r_dx + DYW'(1);
                    end
                end
                r_rem  <= '0;
                r_quot <= r_sum + (r_pend ? SW'(i_rdata) : SW'(0));
                r_step <= '0;
            end
            BK_DIV: begin
                // restoring division, one quotient bit per cycle
                if (shifted >= (CNW+1)'(r_cnt)) begin
                    r_rem  <= shifted - (CNW+1)'(r_cnt);
                    r_quot <= {r_quot[SW-2:0], 1'b1};
                end else begin
                    r_rem  <= shifted;
                    r_quot <= {r_quot[SW-2:0], 1'b0};
                end
                r_step <= r_step + STW'(1);
            end
            default: ;
        endcase
    end

    assign o_idle           = (r_state == BK_IDLE);
    assign o_res.valid      = (r_state == BK_OUT);
    assign o_res.mean_value = r_quot[PIXEL_W-1:0];
    assign o_res.frame_end  = r_last;

    a_cnt_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == BK_SCAN && n_state == BK_DIV) |=> (r_cnt != '0))
        else $error("empty neighborhood at divide");

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == BK_SCAN) |-> (32'(r_cnt) <= KMAX))
        else $error("neighborhood count exceeds kernel size");

    a_mean_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == BK_OUT) |-> (32'(r_quot) <= 255))
        else $error("mean out of pixel range");

    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_job_pop |=> (r_state == BK_SCAN))
        else $error("job popped but scan not started");
endmodule

### design/border_aware_box_filter.sv
// Top level of the border aware box filter.
// Usage:
//   i_pix takes gray pixels in raster order; flush items drain the last outputs
//   once every pixel of the frame is in (a flush during the frame is a bubble).
//   o_res returns one mean per pixel in raster order, frame_end on the last one.
//   i_cfg writes radius, width and height; a write restarts the frame and must
//   only come while the block is idle.
// Result flow:
//   A result is due after radius*width+radius pixels have gone ahead of it.
//   Each result takes a pop, then a window scan at one read per cycle,
//   then a restoring divider that takes a bit per cycle, then an output
//   state that holds until o_res is taken.
//   A pixel that is stored waits until the job queue and the scan unit are
//   empty; drain items only need room in the two-entry job queue.
// Reset: positions clear and the registers take radius 1, 640 x 480; the
//   line store is not cleared, every read falls on a pixel of this frame.
//   Input is held off in the cycle after reset and after each config write.
// Stall: while o_res is not taken the result holds and the scan unit waits;
//   stored pixels wait, drain items are taken until the job queue fills.
module border_aware_box_filter import bab_pkg::*; #(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
    parameter int MAX_RADIUS = DEF_MAX_RADIUS
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    bab_pix_if.sink   i_pix,
    bab_cfg_if.sink   i_cfg,
    bab_res_if.source o_res
);
    localparam int RING = 2 * MAX_RADIUS + 2;
    localparam int RW   = $clog2(RING);
    localparam int CW   = $clog2(MAX_WIDTH);
    localparam int HW   = $clog2(MAX_HEIGHT);
    localparam int DW   = $clog2(MAX_WIDTH + 1);
    localparam int HDW  = $clog2(MAX_HEIGHT + 1);
    localparam int RADW = $clog2(MAX_RADIUS + 1);
    localparam int JW   = HW + CW + RW + 1;

    logic               push, pop, fifo_empty, fifo_full, back_idle, we;
    logic [JW-1:0]      job_in, job_out;
    logic [RW-1:0]      wring, rring;
    logic [CW-1:0]      wcol, rcol;
    logic [PIXEL_W-1:0] wdata, rdata;
    logic [RADW-1:0]    eff_r;
    logic [DW-1:0]      eff_w;
    logic [HDW-1:0]     eff_h;

    bab_front #(
        .MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT), .MAX_RADIUS(MAX_RADIUS)
    ) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_pix(i_pix), .i_cfg(i_cfg),
        .i_fifo_empty(fifo_empty), .i_fifo_full(fifo_full), .i_back_idle(back_idle),
        .o_push(push), .o_job(job_in), .o_we(we), .o_wring(wring), .o_wcol(wcol),
        .o_wdata(wdata), .o_eff_r(eff_r), .o_eff_w(eff_w), .o_eff_h(eff_h)
    );

    bab_job_fifo #(.W(JW)) u_fifo (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(push), .i_data(job_in),
        .i_pop(pop), .o_data(job_out), .o_empty(fifo_empty), .o_full(fifo_full)
    );

    bab_line_mem #(.RING(RING), .MAX_WIDTH(MAX_WIDTH)) u_mem (
        .i_clk(i_clk), .i_we(we), .i_wring(wring), .i_wcol(wcol), .i_wdata(wdata),
        .i_rring(rring), .i_rcol(rcol), .o_rdata(rdata)
    );

    bab_back #(
        .MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT), .MAX_RADIUS(MAX_RADIUS)
    ) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_job_valid(!fifo_empty), .i_job(job_out),
        .o_job_pop(pop), .i_eff_r(eff_r), .i_eff_w(eff_w), .i_eff_h(eff_h),
        .o_rring(rring), .o_rcol(rcol), .i_rdata(rdata), .o_idle(back_idle),
        .o_res(o_res)
    );
endmodule
